// ===== rtl/core/wtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Welch t-test unit package
// Sequencer states, fixed datapath widths and register and verdict codes.
// ----------------------------------------------------------------------------
package wtt_pkg;

    // Fraction bits of a class mean
    localparam int FRAC_BITS  = 20;
    // Fraction bits of the t statistic
    localparam int T_FRAC     = 16;
    // Sum of squared deviations
    localparam int SPREAD_W   = 64;
    // Variance term, spread * 2^40 / (n(n-1))
    localparam int VARQ_W     = 104;
    // Sum of two variance terms
    localparam int SUM_W      = 105;
    // Radicand padded to an even width
    localparam int SQ_W       = 106;
    // Square root of the sum
    localparam int ROOT_W     = 53;
    // Iteration counter
    localparam int STEP_W     = 7;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENOUGH   = 2'd0;
    localparam logic [1:0] CFG_MODERATE = 2'd1;
    localparam logic [1:0] CFG_STRONG   = 2'd2;

    // Verdict codes
    localparam logic [1:0] VERDICT_NOT_ENOUGH = 2'd0;
    localparam logic [1:0] VERDICT_MAYBE      = 2'd1;
    localparam logic [1:0] VERDICT_PROBABLE   = 2'd2;
    localparam logic [1:0] VERDICT_DEFINITE   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN,
        ST_MUL,
        ST_SPREAD,
        ST_NN0,
        ST_VAR0,
        ST_NN1,
        ST_VAR1,
        ST_SQRT,
        ST_TDIV,
        ST_FINISH
    } wtt_state_t;

endpackage

// ===== rtl/core/two_class_welch_t_test_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-class Welch t-test unit
// Welford running statistics per class and Welch's t statistic with verdict.
// ----------------------------------------------------------------------------
// One sample is taken at a time and gives one result transaction. All wide
// arithmetic runs bit-serially: a shared radix-2 restoring divider (mean
// update, both variance terms, the final t division), a shift-add multiplier
// for the spread increment and a radix-4 square root. An item finishes sooner
// when a class still holds under two samples, as the variance, root and t
// steps are then skipped. The next sample is taken while the previous result
// waits in the output register. Configuration writes are accepted in every
// cycle.
module two_class_welch_t_test_unit
    import wtt_pkg::*;
#(
    parameter int SAMPLE_BITS = 20,
    parameter int COUNT_BITS  = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Sample input; tdata: sample
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: sample_class
    input  logic                                  s_tuser,
    // Result output; tdata: t_value
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [31:0]                           m_tdata,
    // tuser: t_valid, verdict
    output logic [2:0]                            m_tuser,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [23:0]                           cfg_data
);

    localparam int MW = SAMPLE_BITS + FRAC_BITS;
    localparam int PW = 2 * MW;
    localparam int DD = (2 * COUNT_BITS > ROOT_W) ? 2 * COUNT_BITS : ROOT_W;
    localparam int REMW = ROOT_W + 2;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    wtt_state_t state_reg, state_next;

    // Configuration
    logic [23:0] enough_reg;
    logic [15:0] moderate_reg;
    logic [15:0] strong_reg;

    // Class statistics
    logic [COUNT_BITS-1:0] cnt_reg [2];
    logic [MW-1:0]         mean_reg [2];
    logic [SPREAD_W-1:0]   spread_reg [2];

    // Item registers
    logic                  cls_reg;
    logic [MW-1:0]         dmag_reg;
    logic                  up_reg;

    // Divider
    logic [VARQ_W-1:0]     dnum_reg;
    logic [DD-1:0]         drem_reg;
    logic [DD-1:0]         ddiv_reg;
    logic [VARQ_W-1:0]     dq_reg;
    logic [STEP_W-1:0]     step_reg;

    // Multiplier
    logic [PW-1:0]         macc_reg;
    logic [MW-1:0]         mb_reg;

    // Variance sum and square root
    logic [SUM_W-1:0]      vsum_reg;
    logic [SQ_W-1:0]       sq_rad_reg;
    logic [REMW-1:0]       sq_rem_reg;
    logic [ROOT_W-1:0]     sq_root_reg;

    // Result in progress and output register
    logic [31:0]           res_mag_reg;
    logic                  res_neg_reg;
    logic                  res_valid_reg;
    logic                  out_v_reg;
    logic [31:0]           out_t_reg;
    logic                  out_tv_reg;
    logic [1:0]            out_verdict_reg;

    logic                  in_fire;
    logic                  last_step;
    logic                  out_free;

    // Sample intake
    logic [MW-1:0]         xq_in;
    logic [MW-1:0]         m_in;
    logic [COUNT_BITS-1:0] n_in;

    // Divider step
    logic [DD:0]           d_shift;
    logic                  d_ge;
    logic [DD:0]           d_sub;
    logic [VARQ_W-1:0]     qf;

    // Mean and spread update
    logic [MW-1:0]         q_mean;
    logic [MW-1:0]         e_val;
    logic [PW-1:0]         m_add;
    logic [PW-1:0]         pf;
    logic [PW:0]           p_round;
    logic [SPREAD_W:0]     sp_sum;

    // Square root step
    logic [REMW-1:0]       s_shift;
    logic [REMW-1:0]       s_trial;
    logic                  s_ge;
    logic [ROOT_W-1:0]     rf;

    // Difference of means
    logic                  mneg;
    logic [MW-1:0]         nmag;
    logic [31:0]           lim;

    // Verdict
    logic [32:0]           total;
    logic [1:0]            verdict;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    assign in_fire   = s_tvalid && s_tready;
    assign last_step = (step_reg == STEP_W'(1));
    assign out_free  = !out_v_reg || m_tready;

    // New sample against its class mean, with the saturating count
    assign xq_in = {s_tdata[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
    assign m_in  = mean_reg[s_tuser];
    assign n_in  = (cnt_reg[s_tuser] == CMAX) ? CMAX : cnt_reg[s_tuser] + 1'b1;

    // One restoring division step
    assign d_shift = {drem_reg, dnum_reg[VARQ_W-1]};
    assign d_ge    = (d_shift >= {1'b0, ddiv_reg});
    assign d_sub   = d_shift - {1'b0, ddiv_reg};
    assign qf      = {dq_reg[VARQ_W-2:0], d_ge};

    // Mean quotient, deviation from the new mean, rounded spread increment
    assign q_mean  = qf[MW-1:0];
    assign e_val   = dmag_reg - q_mean;
    assign m_add   = mb_reg[MW-1] ? PW'(dmag_reg) : '0;
    assign pf      = {macc_reg[PW-2:0], 1'b0} + m_add;
    assign p_round = (PW + 1)'(pf) + ((PW + 1)'(1) << 39);
    assign sp_sum  = {1'b0, spread_reg[cls_reg]} + (SPREAD_W + 1)'(p_round >> 40);

    // One radix-4 square root step
    assign s_shift = {sq_rem_reg[REMW-3:0], sq_rad_reg[SQ_W-1:SQ_W-2]};
    assign s_trial = {sq_root_reg, 2'b01};
    assign s_ge    = (s_shift >= s_trial);
    assign rf      = {sq_root_reg[ROOT_W-2:0], s_ge};

    // Sign and magnitude of mean0 - mean1
    assign mneg = (mean_reg[1] > mean_reg[0]);
    assign nmag = mneg ? mean_reg[1] - mean_reg[0] : mean_reg[0] - mean_reg[1];
    assign lim  = res_neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;

    // Verdict from the final magnitude
    assign total = 33'(cnt_reg[0]) + 33'(cnt_reg[1]);
    always_comb
    begin
        if (!res_valid_reg || total < 33'(enough_reg))
        begin
            verdict = VERDICT_NOT_ENOUGH;
        end
        else if ({1'b0, res_mag_reg} > {1'b0, strong_reg, 16'h0000})
        begin
            verdict = VERDICT_DEFINITE;
        end
        else if ({1'b0, res_mag_reg} > {1'b0, moderate_reg, 16'h0000})
        begin
            verdict = VERDICT_PROBABLE;
        end
        else
        begin
            verdict = VERDICT_MAYBE;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (last_step)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (last_step)
                begin
                    state_next = ST_SPREAD;
                end
            end
            ST_SPREAD:
            begin
                if (cnt_reg[0] >= COUNT_BITS'(2) && cnt_reg[1] >= COUNT_BITS'(2))
                begin
                    state_next = ST_NN0;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_NN0:
            begin
                state_next = ST_VAR0;
            end
            ST_VAR0:
            begin
                if (last_step)
                begin
                    state_next = ST_NN1;
                end
            end
            ST_NN1:
            begin
                state_next = ST_VAR1;
            end
            ST_VAR1:
            begin
                if (last_step)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (last_step)
                begin
                    if (nmag == '0 || rf == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_TDIV;
                    end
                end
            end
            ST_TDIV:
            begin
                if (last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        m_tvalid  = out_v_reg;
        m_tdata   = out_t_reg;
        m_tuser   = {out_verdict_reg, out_tv_reg};
    end

    // ------------------------------------------------------------------
    // Control state, configuration and class statistics
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_v_reg     <= 1'b0;
            enough_reg    <= 24'd10000;
            moderate_reg  <= 16'd10;
            strong_reg    <= 16'd500;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            mean_reg[0]   <= '0;
            mean_reg[1]   <= '0;
            spread_reg[0] <= '0;
            spread_reg[1] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration transaction
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ENOUGH:   enough_reg   <= cfg_data;
                    CFG_MODERATE: moderate_reg <= cfg_data[15:0];
                    CFG_STRONG:   strong_reg   <= cfg_data[15:0];
                    default:      ;
                endcase
            end

            // Output register: loaded when a result is done, freed when taken
            if (state_reg == ST_FINISH && out_free)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end

            // Count update on intake
            if (in_fire)
            begin
                cnt_reg[s_tuser] <= n_in;
            end

            // Mean update after the division
            if (state_reg == ST_MEAN && last_step)
            begin
                mean_reg[cls_reg] <= up_reg ? mean_reg[cls_reg] + q_mean
                                            : mean_reg[cls_reg] - q_mean;
            end

            // Saturating spread update after the multiplication
            if (state_reg == ST_MUL && last_step)
            begin
                spread_reg[cls_reg] <= sp_sum[SPREAD_W] ? '1 : sp_sum[SPREAD_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Serial datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cls_reg  <= s_tuser;
                    up_reg   <= (xq_in >= m_in);
                    dmag_reg <= (xq_in >= m_in) ? xq_in - m_in : m_in - xq_in;
                    dnum_reg <= VARQ_W'((xq_in >= m_in) ? xq_in - m_in : m_in - xq_in)
                                << (VARQ_W - MW);
                    ddiv_reg <= DD'(n_in);
                    drem_reg <= '0;
                    dq_reg   <= '0;
                    step_reg <= STEP_W'(MW);
                end
            end
            ST_MEAN, ST_VAR0, ST_VAR1, ST_TDIV:
            begin
                drem_reg <= d_ge ? d_sub[DD-1:0] : d_shift[DD-1:0];
                dq_reg   <= qf;
                dnum_reg <= {dnum_reg[VARQ_W-2:0], 1'b0};
                step_reg <= step_reg - 1'b1;
                if (last_step)
                begin
                    case (state_reg)
                        ST_MEAN:
                        begin
                            macc_reg <= '0;
                            mb_reg   <= e_val;
                            step_reg <= STEP_W'(MW);
                        end
                        ST_VAR0:
                        begin
                            vsum_reg <= SUM_W'(qf);
                        end
                        ST_VAR1:
                        begin
                            sq_rad_reg  <= SQ_W'(vsum_reg) + SQ_W'(qf);
                            sq_rem_reg  <= '0;
                            sq_root_reg <= '0;
                            step_reg    <= STEP_W'(ROOT_W);
                        end
                        default:
                        begin
                            res_mag_reg <= (qf > VARQ_W'(lim)) ? lim : qf[31:0];
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                macc_reg <= pf;
                mb_reg   <= {mb_reg[MW-2:0], 1'b0};
                step_reg <= step_reg - 1'b1;
            end
            ST_SPREAD:
            begin
                res_mag_reg   <= '0;
                res_neg_reg   <= 1'b0;
                res_valid_reg <= (cnt_reg[0] >= COUNT_BITS'(2)) &&
                                 (cnt_reg[1] >= COUNT_BITS'(2));
            end
            ST_NN0, ST_NN1:
            begin
                ddiv_reg <= DD'(cnt_reg[state_reg == ST_NN1]) *
                            DD'(cnt_reg[state_reg == ST_NN1] - 1'b1);
                dnum_reg <= {spread_reg[state_reg == ST_NN1], 40'h0};
                drem_reg <= '0;
                dq_reg   <= '0;
                step_reg <= STEP_W'(VARQ_W);
            end
            ST_SQRT:
            begin
                sq_rem_reg  <= s_ge ? s_shift - s_trial : s_shift;
                sq_root_reg <= rf;
                sq_rad_reg  <= {sq_rad_reg[SQ_W-3:0], 2'b00};
                step_reg    <= step_reg - 1'b1;
                if (last_step)
                begin
                    res_neg_reg <= mneg;
                    // Equal means give zero; a zero root saturates
                    if (nmag == '0)
                    begin
                        res_mag_reg <= '0;
                    end
                    else if (rf == '0)
                    begin
                        res_mag_reg <= mneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end
                    dnum_reg <= VARQ_W'(nmag) << (VARQ_W - MW);
                    ddiv_reg <= DD'(rf);
                    drem_reg <= '0;
                    dq_reg   <= '0;
                    step_reg <= STEP_W'(MW + T_FRAC);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_t_reg       <= res_neg_reg ? 32'h0 - res_mag_reg : res_mag_reg;
                    out_tv_reg      <= res_valid_reg;
                    out_verdict_reg <= verdict;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== tb/two_class_welch_t_test_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Welch t-test unit testbench
// Drives timing samples of both classes through the unit under random
// sender gaps and receiver stalls. A local model of the Welford update and
// Welch's t statistic predicts every result transaction. Each result is
// compared field by field against that prediction. The verdict registers are
// rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module two_class_welch_t_test_unit_test
    import wtt_pkg::*;
();

    typedef struct packed {
        logic        cls;
        logic [19:0] x;
    } sample_t;

    typedef struct packed {
        logic [31:0] t;
        logic        valid;
        logic [1:0]  verdict;
    } t_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    sample_t   pending_samples[$];
    t_result_t expected_t[$];
    int        errors;
    logic      fire;
    bit        hold_sender;
    int        burst_left;
    int        gap_left;
    int        stall_left;
    int        flow_left;

    // Model of the class statistics and the verdict registers
    logic [63:0] cnt[2];
    logic [63:0] mean_q[2];
    logic [63:0] spread[2];
    logic [63:0] enough_reg;
    logic [63:0] moderate_reg;
    logic [63:0] strong_reg;

    two_class_welch_t_test_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Global time limit
    initial
    begin
        #200_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Variance term spread * 2^40 / (n(n-1)) with n at least two.
    function automatic logic [127:0] variance_term(logic [63:0] sp, logic [63:0] n);
        logic [127:0] num;
        logic [127:0] nn;
        num = {64'd0, sp} << 40;
        nn  = {64'd0, n * (n - 64'd1)};
        return num / nn;
    endfunction

    // Floor square root of a 128-bit radicand, one bit at a time.
    function automatic logic [63:0] floor_root(logic [127:0] s);
        logic [63:0]  res;
        logic [63:0]  cand;
        logic [127:0] sq;
        res = '0;
        for (int i = 63; i >= 0; i--)
        begin
            cand = res | (64'd1 << i);
            sq   = {64'd0, cand} * {64'd0, cand};
            if (sq <= s)
                res = cand;
        end
        return res;
    endfunction

    // Fold one sample into its class and work out the t result.
    function automatic t_result_t fold_sample(sample_t smp);
        logic [63:0]  cmax;
        logic [63:0]  n;
        logic [63:0]  m;
        logic [63:0]  xq;
        logic [63:0]  dmag;
        logic [63:0]  e;
        logic [63:0]  inc;
        logic [63:0]  sp;
        logic [127:0] prod;
        logic [127:0] s;
        logic [127:0] q;
        logic [63:0]  den;
        logic [63:0]  nmag;
        logic [63:0]  tmag;
        logic [63:0]  lim;
        logic         neg;
        int           c;
        t_result_t    r;
        cmax = (64'd1 << 24) - 64'd1;
        c    = smp.cls;
        xq   = {44'd0, smp.x} << 20;
        n    = cnt[c];
        m    = mean_q[c];
        r    = '0;
        if (n < cmax)
            n = n + 64'd1;
        cnt[c] = n;
        if (xq >= m)
        begin
            dmag = xq - m;
            m    = m + dmag / n;
            e    = xq - m;
        end
        else
        begin
            dmag = m - xq;
            m    = m - dmag / n;
            e    = m - xq;
        end
        mean_q[c] = m;
        prod = {64'd0, dmag} * {64'd0, e} + (128'd1 << 39);
        inc  = prod[103:40];
        sp   = spread[c] + inc;
        if (sp < inc)
            sp = '1;
        spread[c] = sp;
        if (cnt[0] >= 2 && cnt[1] >= 2)
        begin
            neg  = mean_q[1] > mean_q[0];
            nmag = neg ? mean_q[1] - mean_q[0] : mean_q[0] - mean_q[1];
            s    = variance_term(spread[0], cnt[0]) + variance_term(spread[1], cnt[1]);
            den  = floor_root(s);
            lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (nmag == 0)
                tmag = 0;
            else if (den == 0)
                tmag = lim;
            else
            begin
                q    = ({64'd0, nmag} << 16) / {64'd0, den};
                tmag = (q > {64'd0, lim}) ? lim : q[63:0];
            end
            r.valid = 1'b1;
            r.t     = neg ? 32'(64'd0 - tmag) : tmag[31:0];
            r.verdict = VERDICT_NOT_ENOUGH;
            if (cnt[0] + cnt[1] >= enough_reg)
            begin
                if (tmag > (strong_reg << 16))
                    r.verdict = VERDICT_DEFINITE;
                else if (tmag > (moderate_reg << 16))
                    r.verdict = VERDICT_PROBABLE;
                else
                    r.verdict = VERDICT_MAYBE;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ENOUGH:   enough_reg   = {40'd0, val};
            CFG_MODERATE: moderate_reg = {48'd0, val[15:0]};
            CFG_STRONG:   strong_reg   = {48'd0, val[15:0]};
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_sample(logic cls, logic [19:0] x);
        sample_t smp;
        smp.cls = cls;
        smp.x   = x;
        pending_samples.push_back(smp);
    endtask

    // Hold off until the sender has emptied its queue and all results are in.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_tvalid || expected_t.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random samples around a per-class level, with some full-range noise.
    task automatic random_phase(int count, int sep, int noise);
        logic [19:0] base;
        logic        cls;
        base = 20'($urandom_range(1000, 900000));
        for (int i = 0; i < count; i++)
        begin
            cls = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 19) == 0)
                add_sample(cls, 20'($urandom));
            else
                add_sample(cls, 20'(base + (cls ? sep : 0) + $urandom_range(0, noise)));
        end
    endtask

    // Sample acceptance and prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fire <= 1'b0;
        else
        begin
            fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                expected_t.push_back(fold_sample({s_tuser, s_tdata[19:0]}));
        end
    end

    // Sample driver: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else if (fire || !s_tvalid)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_samples.size() != 0 && !hold_sender)
            begin
                sample_t smp;
                smp = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'd0, smp.x};
                s_tuser  <= smp.cls;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 500);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver: stalls of random length between free-flowing stretches
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (flow_left > 0)
        begin
            flow_left--;
            m_tready <= 1'b1;
        end
        else
        begin
            flow_left  = $urandom_range(1, 1500);
            stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 600);
            m_tready <= (stall_left == 0);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_t.size() == 0)
                report_mismatch("unexpected result", m_tdata, '0);
            else
            begin
                t_result_t want;
                want = expected_t.pop_front();
                if (m_tdata !== want.t)
                    report_mismatch("t_value", m_tdata, want.t);
                if (m_tuser[0] !== want.valid)
                    report_mismatch("t_valid", m_tuser[0], want.valid);
                if (m_tuser[2:1] !== want.verdict)
                    report_mismatch("verdict", m_tuser[2:1], want.verdict);
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        errors      = 0;
        hold_sender = 1'b0;
        burst_left  = 0;
        gap_left    = 0;
        stall_left  = 0;
        flow_left   = 0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_ENOUGH;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        m_tready    = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            cnt[i]    = '0;
            mean_q[i] = '0;
            spread[i] = '0;
        end
        enough_reg   = 64'd10000;
        moderate_reg = 64'd10;
        strong_reg   = 64'd500;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset settings: one class short, equal means with
        // zero spread, unequal means with one class at zero spread, then the field extremes.
        add_sample(1'b1, 20'd7);
        add_sample(1'b1, 20'd7);
        add_sample(1'b0, 20'd7);
        add_sample(1'b0, 20'd7);
        add_sample(1'b0, 20'd9);
        add_sample(1'b0, 20'd9);
        add_sample(1'b1, 20'd3);
        add_sample(1'b1, 20'hFFFFF);
        add_sample(1'b1, 20'd0);
        add_sample(1'b0, 20'hFFFFF);
        add_sample(1'b0, 20'd0);
        add_sample(1'b0, 20'hAAAAA);
        add_sample(1'b1, 20'h55555);
        add_sample(1'b0, 20'hFFFFF);
        add_sample(1'b1, 20'hFFFFF);
        wait_drained();

        // Extreme settings: verdict always given, strong threshold at maximum
        write_reg(CFG_ENOUGH, 24'd0);
        write_reg(CFG_MODERATE, 24'd0);
        write_reg(CFG_STRONG, 24'd65535);
        random_phase(250, 200, 4000);
        wait_drained();

        // Opposite extremes: verdict never reached, then thresholds swapped
        write_reg(CFG_ENOUGH, 24'hFFFFFF);
        write_reg(CFG_MODERATE, 24'd65535);
        write_reg(CFG_STRONG, 24'd0);
        random_phase(250, 50000, 2000);
        wait_drained();

        // Mid-range settings with a count threshold crossed during the phase
        write_reg(CFG_ENOUGH, 24'(cnt[0] + cnt[1] + 60));
        write_reg(CFG_MODERATE, 24'd2);
        write_reg(CFG_STRONG, 24'd20);
        random_phase(250, 3000, 30000);
        wait_drained();

        // Random settings
        write_reg(CFG_ENOUGH, 24'($urandom_range(0, 1500)));
        write_reg(CFG_MODERATE, 24'($urandom_range(0, 40)));
        write_reg(CFG_STRONG, 24'($urandom_range(0, 200)));
        random_phase(250, $urandom_range(0, 20000), $urandom_range(0, 100000));
        wait_drained();

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/wtt_pkg.sv
rtl/core/two_class_welch_t_test_unit.sv
tb/two_class_welch_t_test_unit_test.sv
